@@ hdl/arlp_pkg.sv @@
// ----------------------------------------------------------------------------
// arlp_pkg
// Shared constants, byte codes and types of the AT response line parser.
// ----------------------------------------------------------------------------
package arlp_pkg;

	localparam int LINE_BYTES    = 32;
	localparam int CAPTURE_BYTES = 256;
	localparam int QUEUE_DEPTH   = 2;

	localparam int FILL_W  = $clog2(LINE_BYTES + 1);
	localparam int CAP_W   = $clog2(CAPTURE_BYTES);
	localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_ASCII_MAX = 8'h7F;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_DIGIT0    = 8'h30;

	// line positions the signal level digits are taken from
	localparam int DIG_POS_HI = 6;
	localparam int DIG_POS_LO = 7;

	localparam int PROMPT_LEN = 2;
	localparam int OK_LEN     = 2;
	localparam int CSQ_LEN    = 6;
	localparam int CSQ_ST_W   = $clog2(CSQ_LEN);

	localparam logic [7:0] PROMPT_PAT [PROMPT_LEN] = '{8'h3E, 8'h20};
	localparam logic [7:0] OK_PAT     [OK_LEN]     = '{8'h4F, 8'h4B};
	localparam logic [7:0] CSQ_PAT    [CSQ_LEN]    =
		'{8'h2B, 8'h43, 8'h53, 8'h51, 8'h3A, 8'h20};

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0]            data;
		logic                  is_high;
		logic                  is_lf;
		logic                  is_zero;
		logic [PROMPT_LEN-1:0] prompt_hit;
		logic [OK_LEN-1:0]     ok_hit;
		logic [CSQ_LEN-1:0]    csq_hit;
		logic                  cap_en;
	} cls_t;

	// one result
	typedef struct packed {
		logic       prompt_seen;
		logic       ok_seen;
		logic       level_valid;
		logic [7:0] signal_level;
		logic       capture_write;
		logic [7:0] capture_index;
		logic [7:0] capture_byte;
	} res_t;

endpackage

@@ hdl/arlp_front.sv @@
// ----------------------------------------------------------------------------
// arlp_front
// Accepts receive bytes and classifies them against the pattern characters.
// ----------------------------------------------------------------------------
module arlp_front (
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	input  logic                cap_en,
	input  logic                q_full,
	output logic                push,
	output arlp_pkg::cls_t      cls
);

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		cls         = '0;
		cls.data    = rx_byte;
		cls.is_high = rx_byte > arlp_pkg::CH_ASCII_MAX;
		cls.is_lf   = rx_byte == arlp_pkg::CH_LF;
		cls.is_zero = rx_byte == 8'h00;
		cls.cap_en  = cap_en;
		for (int k = 0; k < arlp_pkg::PROMPT_LEN; k++) begin
			cls.prompt_hit[k] = rx_byte == arlp_pkg::PROMPT_PAT[k];
		end
		for (int k = 0; k < arlp_pkg::OK_LEN; k++) begin
			cls.ok_hit[k] = rx_byte == arlp_pkg::OK_PAT[k];
		end
		for (int k = 0; k < arlp_pkg::CSQ_LEN; k++) begin
			cls.csq_hit[k] = rx_byte == arlp_pkg::CSQ_PAT[k];
		end
	end

endmodule

@@ hdl/arlp_fifo.sv @@
// ----------------------------------------------------------------------------
// arlp_fifo
// Short queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module arlp_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  arlp_pkg::cls_t      din,
	input  logic                pop,
	output arlp_pkg::cls_t      dout,
	output logic                not_empty,
	output logic                full
);

	arlp_pkg::cls_t                 mem_q [arlp_pkg::QUEUE_DEPTH];
	logic [arlp_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [arlp_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [arlp_pkg::QCNT_W-1:0]    count_q;

	function automatic logic [arlp_pkg::QPTR_W-1:0] ptr_inc(
		input logic [arlp_pkg::QPTR_W-1:0] p
	);
		return (p == arlp_pkg::QPTR_W'(arlp_pkg::QUEUE_DEPTH - 1)) ?
			'0 : p + 1'b1;
	endfunction

	assign not_empty = count_q != '0;
	assign full      = count_q == arlp_pkg::QCNT_W'(arlp_pkg::QUEUE_DEPTH);
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/arlp_back.sv @@
// ----------------------------------------------------------------------------
// arlp_back
// Line state with rolling matchers, level decode, capture position and the
// output register.
// ----------------------------------------------------------------------------
module arlp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  arlp_pkg::cls_t      cls,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output arlp_pkg::res_t      res
);

	logic [arlp_pkg::FILL_W-1:0]   fill_q, fill_n;
	logic                          text_end_q, text_end_n;
	logic                          prompt_st_q, prompt_st_n;
	logic                          ok_st_q, ok_st_n;
	logic                          has_ok_q, has_ok_n;
	logic [arlp_pkg::CSQ_ST_W-1:0] csq_st_q, csq_st_n;
	logic                          has_csq_q, has_csq_n;
	logic [7:0]                    dig_hi_q, dig_hi_n;
	logic [7:0]                    dig_lo_q, dig_lo_n;
	logic [7:0]                    level_q, level_n;
	logic [arlp_pkg::CAP_W-1:0]    cap_pos_q, cap_pos_n;
	logic                          out_valid_q;
	arlp_pkg::res_t                res_q, res_n;

	logic       stored;
	logic       adv;
	logic       prompt_hit;
	logic       clear;
	logic [7:0] d_hi, d_lo, lvl_calc;

	assign q_pop     = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		stored = fill_q < arlp_pkg::FILL_W'(arlp_pkg::LINE_BYTES);
		// byte extends the text only before a stored zero
		adv    = stored && !text_end_q;

		fill_n     = stored ? fill_q + 1'b1 : fill_q;
		text_end_n = text_end_q || (stored && cls.is_zero);
		dig_hi_n   = (stored && fill_q == arlp_pkg::FILL_W'(arlp_pkg::DIG_POS_HI)) ?
			cls.data : dig_hi_q;
		dig_lo_n   = (stored && fill_q == arlp_pkg::FILL_W'(arlp_pkg::DIG_POS_LO)) ?
			cls.data : dig_lo_q;

		prompt_hit  = adv && prompt_st_q && cls.prompt_hit[1];
		prompt_st_n = adv ? cls.prompt_hit[0] : prompt_st_q;

		ok_st_n  = adv ? cls.ok_hit[0] : ok_st_q;
		has_ok_n = has_ok_q || (adv && ok_st_q && cls.ok_hit[1]);

		csq_st_n  = csq_st_q;
		has_csq_n = has_csq_q;
		if (adv) begin
			if (cls.csq_hit[csq_st_q]) begin
				if (csq_st_q == arlp_pkg::CSQ_ST_W'(arlp_pkg::CSQ_LEN - 1)) begin
					has_csq_n = 1'b1;
					csq_st_n  = cls.csq_hit[0] ? arlp_pkg::CSQ_ST_W'(1) : '0;
				end else begin
					csq_st_n = csq_st_q + 1'b1;
				end
			end else begin
				csq_st_n = cls.csq_hit[0] ? arlp_pkg::CSQ_ST_W'(1) : '0;
			end
		end

		d_hi     = dig_hi_n - arlp_pkg::CH_DIGIT0;
		d_lo     = dig_lo_n - arlp_pkg::CH_DIGIT0;
		lvl_calc = (d_hi << 3) + (d_hi << 1) + d_lo;

		res_n               = '0;
		res_n.capture_write = cls.cap_en;
		if (cls.cap_en) begin
			res_n.capture_index = 8'(cap_pos_q);
			res_n.capture_byte  = cls.data;
			cap_pos_n = (cap_pos_q == arlp_pkg::CAP_W'(arlp_pkg::CAPTURE_BYTES - 1)) ?
				'0 : cap_pos_q + 1'b1;
		end else begin
			cap_pos_n = cap_pos_q;
		end

		level_n = level_q;
		clear   = 1'b0;
		if (cls.is_high) begin
			clear = 1'b1;
		end else if (prompt_hit) begin
			res_n.prompt_seen = 1'b1;
			clear             = 1'b1;
		end else if (cls.is_lf) begin
			clear = 1'b1;
			if (has_csq_n) begin
				res_n.level_valid = 1'b1;
				level_n           = lvl_calc;
			end
			if (has_ok_n) begin
				res_n.ok_seen = 1'b1;
				cap_pos_n     = '0;
			end
		end
		res_n.signal_level = level_n;

		if (clear) begin
			fill_n      = '0;
			text_end_n  = 1'b0;
			prompt_st_n = 1'b0;
			ok_st_n     = 1'b0;
			has_ok_n    = 1'b0;
			csq_st_n    = '0;
			has_csq_n   = 1'b0;
			dig_hi_n    = '0;
			dig_lo_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			text_end_q  <= 1'b0;
			prompt_st_q <= 1'b0;
			ok_st_q     <= 1'b0;
			has_ok_q    <= 1'b0;
			csq_st_q    <= '0;
			has_csq_q   <= 1'b0;
			dig_hi_q    <= '0;
			dig_lo_q    <= '0;
			level_q     <= '0;
			cap_pos_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				fill_q      <= fill_n;
				text_end_q  <= text_end_n;
				prompt_st_q <= prompt_st_n;
				ok_st_q     <= ok_st_n;
				has_ok_q    <= has_ok_n;
				csq_st_q    <= csq_st_n;
				has_csq_q   <= has_csq_n;
				dig_hi_q    <= dig_hi_n;
				dig_lo_q    <= dig_lo_n;
				level_q     <= level_n;
				cap_pos_q   <= cap_pos_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= res_n;
		end
	end

endmodule

@@ hdl/at_response_line_parser.sv @@
// ----------------------------------------------------------------------------
// at_response_line_parser
// Parses modem receive bytes for the prompt, OK and +CSQ: lines and emits
// one result per byte, optionally with a capture store write.
// ----------------------------------------------------------------------------
// a byte accepted into the two-entry queue is classified on the way in; the
//   back pops it, updates its line state and registers the result
// throughput: one byte per cycle while the output is not stalled
// reset clears line state, signal level, capture position and capture_enable
module at_response_line_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       prompt_seen,
	output logic       ok_seen,
	output logic       level_valid,
	output logic [7:0] signal_level,
	output logic       capture_write,
	output logic [7:0] capture_index,
	output logic [7:0] capture_byte
);

	logic              capture_enable_q;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_not_empty;
	arlp_pkg::cls_t    cls_in;
	arlp_pkg::cls_t    cls_head;
	arlp_pkg::res_t    res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			capture_enable_q <= cfg_data;
		end
	end

	arlp_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.cap_en   (capture_enable_q),
		.q_full   (q_full),
		.push     (push),
		.cls      (cls_in)
	);

	arlp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (cls_in),
		.pop       (pop),
		.dout      (cls_head),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	arlp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.cls       (cls_head),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign prompt_seen   = res.prompt_seen;
	assign ok_seen       = res.ok_seen;
	assign level_valid   = res.level_valid;
	assign signal_level  = res.signal_level;
	assign capture_write = res.capture_write;
	assign capture_index = res.capture_index;
	assign capture_byte  = res.capture_byte;

	// prompt consumes the line, so no line-end report can come with it
	a_prompt_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && prompt_seen |-> !ok_seen && !level_valid)
		else $error("prompt reported together with line end");

	a_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !capture_write |-> capture_index == 8'h00 && capture_byte == 8'h00)
		else $error("capture fields not zero without capture write");

	// a request taken into an empty parser while capture is on comes back as a capture write of the same byte
	a_capture_echo: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid && q_not_empty == 1'b0 && capture_enable_q
		|-> ##2 out_valid && capture_write && capture_byte == $past(rx_byte, 2))
		else $error("captured byte differs from received byte");

	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall ##1 out_valid && !level_valid && pop == 1'b0
		|-> $stable(signal_level))
		else $error("signal level changed without level update");

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for at_response_line_parser: feeds modem byte streams
// (prompts, OK and +CSQ: lines, long lines, noise) under random idling on
// both sides, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT = 200000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       prompt_seen;
	logic       ok_seen;
	logic       level_valid;
	logic [7:0] signal_level;
	logic       capture_write;
	logic [7:0] capture_index;
	logic [7:0] capture_byte;

	at_response_line_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.prompt_seen   (prompt_seen),
		.ok_seen       (ok_seen),
		.level_valid   (level_valid),
		.signal_level  (signal_level),
		.capture_write (capture_write),
		.capture_index (capture_index),
		.capture_byte  (capture_byte)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	logic [7:0]     rx_q [$];
	arlp_pkg::res_t parsed_q [$];
	int             tx_idle_pct = 0;
	int             rx_stall_pct = 0;
	int             err_cnt = 0;
	int             cycle_cnt = 0;
	logic           in_fire = 1'b0;

	// parser state as the block should hold it
	logic [7:0] line_buf [arlp_pkg::LINE_BYTES];
	int         line_len = 0;
	int         cap_pos = 0;
	logic [7:0] level = 8'h00;
	logic       cap_en = 1'b0;

	initial begin
		for (int i = 0; i < arlp_pkg::LINE_BYTES; i++)
			line_buf[i] = 8'h00;
	end

	function automatic void wipe_line();
		for (int i = 0; i < arlp_pkg::LINE_BYTES; i++)
			line_buf[i] = 8'h00;
		line_len = 0;
	endfunction

	// text search stops at the first stored zero byte
	function automatic bit line_holds(string pat);
		int n;
		bit hit;
		bit same;
		n = 0;
		while (n < arlp_pkg::LINE_BYTES && line_buf[n] != 8'h00)
			n++;
		hit = 0;
		for (int s = 0; s + pat.len() <= n; s++) begin
			same = 1;
			for (int k = 0; k < pat.len(); k++)
				if (line_buf[s + k] != pat[k])
					same = 0;
			if (same)
				hit = 1;
		end
		return hit;
	endfunction

	function automatic arlp_pkg::res_t parse_byte(logic [7:0] b);
		arlp_pkg::res_t r;
		bit lf;
		logic [7:0] d_hi;
		logic [7:0] d_lo;
		r = '0;
		lf = (b == arlp_pkg::CH_LF);
		if (line_len < arlp_pkg::LINE_BYTES) begin
			line_buf[line_len] = b;
			line_len++;
		end
		if (cap_en) begin
			r.capture_write = 1'b1;
			r.capture_index = cap_pos[7:0];
			r.capture_byte = b;
			cap_pos = (cap_pos + 1) % arlp_pkg::CAPTURE_BYTES;
		end
		if (b > arlp_pkg::CH_ASCII_MAX) begin
			wipe_line();
		end else begin
			if (line_holds("> ")) begin
				r.prompt_seen = 1'b1;
				wipe_line();
				lf = 0;
			end
			if (lf) begin
				if (line_holds("+CSQ: ")) begin
					d_hi = line_buf[arlp_pkg::DIG_POS_HI] - arlp_pkg::CH_DIGIT0;
					d_lo = line_buf[arlp_pkg::DIG_POS_LO] - arlp_pkg::CH_DIGIT0;
					level = d_hi * 8'd10 + d_lo;
					r.level_valid = 1'b1;
				end
				if (line_holds("OK")) begin
					r.ok_seen = 1'b1;
					cap_pos = 0;
				end
				wipe_line();
			end
		end
		r.signal_level = level;
		return r;
	endfunction

	task automatic match_field(string fname, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
			err_cnt++;
		end
	endtask

	// monitor: config and requests update the prediction, results are checked
	always @(posedge clk) begin
		arlp_pkg::res_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				cap_en = cfg_data;
			if (in_valid && !in_stall)
				parsed_q.push_back(parse_byte(rx_byte));
			if (out_valid && !out_stall) begin
				if (parsed_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual level %0d",
						$time, signal_level);
					err_cnt++;
				end else begin
					want = parsed_q.pop_front();
					match_field("prompt_seen", int'(want.prompt_seen), int'(prompt_seen));
					match_field("ok_seen", int'(want.ok_seen), int'(ok_seen));
					match_field("level_valid", int'(want.level_valid), int'(level_valid));
					match_field("signal_level", int'(want.signal_level),
						int'(signal_level));
					match_field("capture_write", int'(want.capture_write),
						int'(capture_write));
					match_field("capture_index", int'(want.capture_index),
						int'(capture_index));
					match_field("capture_byte", int'(want.capture_byte),
						int'(capture_byte));
				end
			end
		end
		in_fire <= in_valid && !in_stall;
	end

	// driver: next request once the current one is taken, random gaps
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
		if (!in_valid || in_fire) begin
			if (arst_n && rx_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				in_valid <= 1'b1;
				rx_byte <= rx_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAIL at_response_line_parser");
			$finish;
		end
	end

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			rx_q.push_back(s[i]);
	endtask

	task automatic push_printable(int n);
		for (int i = 0; i < n; i++)
			rx_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
	endtask

	task automatic push_random_line();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			push_printable($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
			push_text("+CSQ: ");
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++)
				if ($urandom_range(0, 7) == 0)
					rx_q.push_back(8'($urandom_range(8'h01, 8'h7F)));
				else
					rx_q.push_back(8'(arlp_pkg::CH_DIGIT0 + $urandom_range(0, 9)));
			if ($urandom_range(0, 1))
				push_text(",99");
			rx_q.push_back(arlp_pkg::CH_LF);
		end else if (pick < 35) begin
			push_printable($urandom_range(0, 2));
			push_text("OK");
			push_printable($urandom_range(0, 2));
			rx_q.push_back(arlp_pkg::CH_LF);
		end else if (pick < 50) begin
			push_printable($urandom_range(0, 4));
			push_text("> ");
		end else if (pick < 62) begin
			// can run past the end of the line store
			push_printable($urandom_range(28, 40));
			if ($urandom_range(0, 2) == 0)
				push_text("OK");
			else if ($urandom_range(0, 1))
				push_text("+CSQ: 12");
			rx_q.push_back(arlp_pkg::CH_LF);
		end else if (pick < 80) begin
			push_printable($urandom_range(0, 10));
			rx_q.push_back(arlp_pkg::CH_LF);
		end else if (pick < 90) begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				case ($urandom_range(0, 5))
					0: rx_q.push_back(arlp_pkg::CH_LF);
					1: rx_q.push_back(8'h00);
					2: rx_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
					default: rx_q.push_back(8'($urandom_range(0, 255)));
				endcase
		end else begin
			// broken patterns
			case ($urandom_range(0, 3))
				0: begin
					push_text("+CS");
					rx_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
					push_text("Q: 12");
				end
				1: begin
					push_text("O");
					rx_q.push_back(8'h00);
					push_text("K");
				end
				2: begin
					push_text(">");
					rx_q.push_back(arlp_pkg::CH_LF);
					push_text(" ");
				end
				default: push_text("+CSQ:");
			endcase
			rx_q.push_back(arlp_pkg::CH_LF);
		end
	endtask

	task automatic write_capture_enable(logic v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		do @(posedge clk); while (rx_q.size() != 0 || in_valid || parsed_q.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 26;
		rx_stall_pct = 73;
		write_capture_enable(1'b1);
		push_text("> ");
		push_text("+CSQ: 99");
		rx_q.push_back(arlp_pkg::CH_LF);
		push_text("OK");
		rx_q.push_back(arlp_pkg::CH_LF);
		rx_q.push_back(8'hFF);
		rx_q.push_back(8'h7F);
		rx_q.push_back(8'h00);
		rx_q.push_back(arlp_pkg::CH_LF);
		// short level line: digit positions hold the line feed and nothing
		push_text("+CSQ: ");
		rx_q.push_back(arlp_pkg::CH_LF);
		// zero byte ends the text, so the level line behind it is not seen
		rx_q.push_back(8'h00);
		push_text("+CSQ: 4");
		rx_q.push_back(arlp_pkg::CH_LF);
		drain();

		for (int ep = 0; ep < 3; ep++) begin
			tx_idle_pct = (ep == 0) ? 26 : (ep == 1) ? 73 : 0;
			rx_stall_pct = (ep == 0) ? 73 : (ep == 1) ? 26 : 0;
			for (int ph = 0; ph < 2; ph++) begin
				write_capture_enable(1'((ph ^ ep) & 1));
				while (rx_q.size() < 320)
					push_random_line();
				drain();
			end
		end

		if (err_cnt == 0 && parsed_q.size() == 0)
			$display("PASS at_response_line_parser");
		else
			$display("FAIL at_response_line_parser");
		$finish;
	end

endmodule
